// ===== rtl/pfac_pkg.sv =====
package pfac_pkg;

  // Width of decoded positions and counters; values saturate at all ones.
  localparam int COUNT_WIDTH = 8;
  localparam int ACC_W       = COUNT_WIDTH + 4;
  localparam int CMP_W       = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  // Token queue between the classifier and the parser.
  localparam int TOKQ_AW    = 1;
  localparam int TOKQ_DEPTH = 1 << TOKQ_AW;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_Z    = 8'h7A;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_Z    = 8'h5A;
  localparam logic [7:0] CH_LC_L    = 8'h6C;
  localparam logic [7:0] CH_LC_H    = 8'h68;
  localparam logic [7:0] CH_UC_L    = 8'h4C;
  localparam logic [7:0] CH_LC_ZED  = 8'h7A;
  localparam logic [7:0] CH_LC_J    = 8'h6A;
  localparam logic [7:0] CH_LC_T    = 8'h74;

  typedef enum logic [2:0] {
    TK_OTHER   = 3'd0,
    TK_PERCENT = 3'd1,
    TK_DOLLAR  = 3'd2,
    TK_STAR    = 3'd3,
    TK_DIGIT   = 3'd4,
    TK_CONV    = 3'd5
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    logic       last;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } tok_req_t;

  // accum * 10 + d, saturated to the counter range
  function automatic count_t add_digit(count_t acc, logic [3:0] d);
    logic [ACC_W-1:0] v;
    v = (ACC_W'(acc) << 3) + (ACC_W'(acc) << 1) + ACC_W'(d);
    if (v > ACC_W'(COUNT_MAX)) return COUNT_MAX;
    return v[COUNT_WIDTH-1:0];
  endfunction

  function automatic count_t sat_inc(count_t n);
    if (n == COUNT_MAX) return n;
    return n + count_t'(1);
  endfunction

  function automatic logic [7:0] clamp_arg(count_t n);
    logic [CMP_W-1:0] w;
    w = CMP_W'(n);
    if (w > CMP_W'(255)) return 8'hFF;
    return w[7:0];
  endfunction

endpackage

// ===== rtl/pfac_classify.sv =====
module pfac_classify (
  input  logic            [7:0] char_code,
  input  logic                  last_char,
  output pfac_pkg::token_t      tok
);
  import pfac_pkg::*;

  logic is_letter;
  logic is_modifier;

  always_comb begin
    is_letter   = ((char_code >= CH_LC_A) && (char_code <= CH_LC_Z)) ||
                  ((char_code >= CH_UC_A) && (char_code <= CH_UC_Z));
    is_modifier = (char_code == CH_LC_L) || (char_code == CH_LC_H) ||
                  (char_code == CH_UC_L) || (char_code == CH_LC_ZED) ||
                  (char_code == CH_LC_J) || (char_code == CH_LC_T);
    tok.last  = last_char;
    tok.digit = 4'(char_code - CH_ZERO);
    if (char_code == CH_PERCENT) begin
      tok.kind = TK_PERCENT;
    end else if (char_code == CH_DOLLAR) begin
      tok.kind = TK_DOLLAR;
    end else if (char_code == CH_STAR) begin
      tok.kind = TK_STAR;
    end else if ((char_code >= CH_ZERO) && (char_code <= CH_NINE)) begin
      tok.kind = TK_DIGIT;
    end else if (is_letter && !is_modifier) begin
      tok.kind = TK_CONV;
    end else begin
      tok.kind = TK_OTHER;
    end
  end

endmodule

// ===== rtl/pfac_token_fifo.sv =====
module pfac_token_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  pfac_pkg::token_t   wr_tok,
  output logic               full,
  input  logic               rd_en,
  output pfac_pkg::tok_req_t rd_req
);
  import pfac_pkg::*;

  token_t             mem [TOKQ_DEPTH];
  logic [TOKQ_AW-1:0] wr_ptr;
  logic [TOKQ_AW-1:0] rd_ptr;
  logic [TOKQ_AW:0]   cnt;

  assign full         = (cnt == (TOKQ_AW+1)'(TOKQ_DEPTH));
  assign rd_req.valid = (cnt != '0);
  assign rd_req.tok   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + TOKQ_AW'(1);
      if (rd_en) rd_ptr <= rd_ptr + TOKQ_AW'(1);
      unique case ({wr_en, rd_en})
        2'b10:   cnt <= cnt + (TOKQ_AW+1)'(1);
        2'b01:   cnt <= cnt - (TOKQ_AW+1)'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== rtl/pfac_parser.sv =====
module pfac_parser (
  input  logic               clk,
  input  logic               rst,
  input  pfac_pkg::tok_req_t tok_req,
  output logic               tok_take,
  output logic               empty,
  input  logic               pop,
  output logic         [7:0] arg_count,
  output logic               uses_positions
);
  import pfac_pkg::*;

  typedef enum logic [4:0] {
    MODE_PLAIN   = 5'b00001,
    MODE_PERCENT = 5'b00010,
    MODE_SPEC    = 5'b00100,
    MODE_WALK    = 5'b01000,
    MODE_STAR    = 5'b10000
  } mode_t;

  mode_t  mode, mode_next;
  count_t acc, acc_next;
  logic   dp, dp_next;
  count_t spos, spos_next;
  count_t seq, seq_next;
  count_t maxp, maxp_next;
  logic   seen, seen_next;

  logic   out_valid;
  count_t res_count;
  logic   res_pos;
  logic   do_walk;
  token_t t;

  assign t        = tok_req.tok;
  assign empty    = !out_valid;
  // a final byte waits until the result slot is free or being drained
  assign tok_take = tok_req.valid && (!t.last || !out_valid || pop);

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    dp_next   = dp;
    spos_next = spos;
    seq_next  = seq;
    maxp_next = maxp;
    seen_next = seen;
    do_walk   = 1'b0;
    res_count = '0;
    res_pos   = 1'b0;

    unique case (mode)
      MODE_PLAIN: begin
        if (t.kind == TK_PERCENT) mode_next = MODE_PERCENT;
      end
      MODE_PERCENT: begin
        if (t.kind == TK_PERCENT) begin
          mode_next = MODE_PLAIN;
        end else begin
          spos_next = '0;
          acc_next  = '0;
          dp_next   = 1'b0;
          if (t.kind == TK_DIGIT) begin
            acc_next  = add_digit('0, t.digit);
            dp_next   = 1'b1;
            mode_next = MODE_SPEC;
          end else begin
            do_walk = 1'b1;
          end
        end
      end
      MODE_SPEC: begin
        if (t.kind == TK_DIGIT) begin
          acc_next = add_digit(acc, t.digit);
          dp_next  = 1'b1;
        end else if (t.kind == TK_DOLLAR) begin
          spos_next = acc;
          if (acc != '0) begin
            seen_next = 1'b1;
            if (acc > maxp) maxp_next = acc;
          end
          mode_next = MODE_WALK;
        end else begin
          spos_next = '0;
          do_walk   = 1'b1;
        end
      end
      MODE_STAR: begin
        if (t.kind == TK_DIGIT) begin
          acc_next = add_digit(acc, t.digit);
          dp_next  = 1'b1;
        end else if (t.kind == TK_DOLLAR && dp) begin
          if (acc != '0) begin
            seen_next = 1'b1;
            if (acc > maxp) maxp_next = acc;
          end else begin
            seq_next = sat_inc(seq_next);
          end
          mode_next = MODE_WALK;
        end else begin
          seq_next = sat_inc(seq_next);
          do_walk  = 1'b1;
        end
      end
      MODE_WALK: begin
        do_walk = 1'b1;
      end
      default: begin
        do_walk = 1'b1;
      end
    endcase

    if (do_walk) begin
      if (t.kind == TK_STAR) begin
        acc_next  = '0;
        dp_next   = 1'b0;
        mode_next = MODE_STAR;
      end else if (t.kind == TK_CONV) begin
        if (spos_next == '0) seq_next = sat_inc(seq_next);
        mode_next = MODE_PLAIN;
      end else begin
        mode_next = MODE_WALK;
      end
    end

    if (t.last) begin
      // a star still open at the end counts as one argument
      if (mode_next == MODE_STAR) seq_next = sat_inc(seq_next);
      res_count = seen_next ? maxp_next : seq_next;
      res_pos   = seen_next;
      mode_next = MODE_PLAIN;
      acc_next  = '0;
      dp_next   = 1'b0;
      spos_next = '0;
      seq_next  = '0;
      maxp_next = '0;
      seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_PLAIN;
      acc       <= '0;
      dp        <= 1'b0;
      spos      <= '0;
      seq       <= '0;
      maxp      <= '0;
      seen      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (tok_take) begin
        mode <= mode_next;
        acc  <= acc_next;
        dp   <= dp_next;
        spos <= spos_next;
        seq  <= seq_next;
        maxp <= maxp_next;
        seen <= seen_next;
      end
      if (tok_take && t.last) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take && t.last) begin
      arg_count      <= clamp_arg(res_count);
      uses_positions <= res_pos;
    end
  end

endmodule

// ===== rtl/printf_format_arg_counter.sv =====
// Counts the arguments a printf-style format string consumes. Push one byte per
// cycle with last_char set on the final byte; one result (arg_count, and
// uses_positions when any N$ with N>0 appeared) is queued per string. Sustained
// rate is one byte per cycle unless the parser stalls on a final byte, set by
// the parser's state update; with nothing queued ahead of it, a final byte passes
// through the token queue into the parser, which registers its result.
// A two-entry token queue sits between the byte classifier and the parser, and
// a one-deep result slot lets bytes keep flowing while a result waits. The
// parser only stalls on a final byte while the previous result is still held.
// Empty strings must not be presented.
module printf_format_arg_counter (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] arg_count,
  output logic       uses_positions
);
  import pfac_pkg::*;

  token_t   in_tok;
  tok_req_t q_req;
  logic     q_take;
  logic     q_full;
  logic     wr_en;

  assign full  = q_full;
  assign wr_en = push && !q_full;

  pfac_classify u_classify (
    .char_code (char_code),
    .last_char (last_char),
    .tok       (in_tok)
  );

  pfac_token_fifo u_tokq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_tok (in_tok),
    .full   (q_full),
    .rd_en  (q_take),
    .rd_req (q_req)
  );

  pfac_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .tok_req        (q_req),
    .tok_take       (q_take),
    .empty          (empty),
    .pop            (pop),
    .arg_count      (arg_count),
    .uses_positions (uses_positions)
  );

endmodule

// ===== rtl/pfac_checker.sv =====
module pfac_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic [7:0] char_code,
  input logic       last_char,
  input logic       empty,
  input logic       pop,
  input logic [7:0] arg_count,
  input logic       uses_positions
);

  // strings whose final byte went in but whose result was not yet taken
  logic [2:0] pending;
  logic       str_in;
  logic       str_out;

  assign str_in  = push && !full && last_char;
  assign str_out = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (str_in && !str_out) begin
      pending <= pending + 3'd1;
    end else if (str_out && !str_in) begin
      pending <= pending - 3'd1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(arg_count) && $stable(uses_positions)))
    else $error("waiting result changed before it was taken");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pending != 3'd0))
    else $error("result shown without a finished string");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && uses_positions) |-> (arg_count != 8'd0))
    else $error("positional result with zero count");

  a_char_known: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |-> !$isunknown(char_code))
    else $error("unknown byte accepted");

endmodule

bind printf_format_arg_counter pfac_checker u_pfac_checker (.*);

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfac_pkg::*;

  localparam int CMAX = (1 << COUNT_WIDTH) - 1;
  localparam int RAND_BYTES = 700;

  localparam logic [7:0] K_PCT    = "%";
  localparam logic [7:0] K_DOLLAR = "$";
  localparam logic [7:0] K_STAR   = "*";
  localparam logic [7:0] K_ZERO   = "0";
  localparam logic [7:0] K_NINE   = "9";

  typedef enum int {M_PLAIN, M_PCT, M_POSN, M_WALK, M_STAR} parse_mode_e;

  typedef struct packed {
    logic [7:0] cnt;
    logic       pos;
  } arg_result_t;

  class arg_count_sb;
    parse_mode_e mode;
    int          acc;
    bit          have_digits;
    int          spec_pos;
    int          seq_cnt;
    int          max_pos;
    bit          pos_seen;
    arg_result_t expected_q[$];
    int          errors;
    int          n_checked;
    int          n_positional;
    int          n_saturated;

    function new();
      clear();
      errors = 0;
      n_checked = 0;
      n_positional = 0;
      n_saturated = 0;
    endfunction

    function void clear();
      mode = M_PLAIN;
      acc = 0;
      have_digits = 0;
      spec_pos = 0;
      seq_cnt = 0;
      max_pos = 0;
      pos_seen = 0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= K_ZERO && c <= K_NINE;
    endfunction

    function bit is_conv(logic [7:0] c);
      bit letter;
      letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      return letter && c != "l" && c != "h" && c != "L" && c != "z" &&
             c != "j" && c != "t";
    endfunction

    function void add_digit(logic [7:0] c);
      int v;
      v = acc * 10 + (int'(c) - int'(K_ZERO));
      acc = (v > CMAX) ? CMAX : v;
      have_digits = 1;
    endfunction

    function void bump();
      if (seq_cnt < CMAX) seq_cnt++;
    endfunction

    function void note_pos(int p);
      if (p > 0) begin
        pos_seen = 1;
        if (p > max_pos) max_pos = p;
      end
    endfunction

    function void walk(logic [7:0] c);
      if (c == K_STAR) begin
        acc = 0;
        have_digits = 0;
        mode = M_STAR;
      end else if (is_conv(c)) begin
        if (spec_pos == 0) bump();
        mode = M_PLAIN;
      end else begin
        mode = M_WALK;
      end
    endfunction

    // advance the parser by one accepted byte; queue a result on the final one
    function void note_byte(logic [7:0] c, logic last);
      int n;
      arg_result_t r;
      case (mode)
        M_PLAIN: begin
          if (c == K_PCT) mode = M_PCT;
        end
        M_PCT: begin
          if (c == K_PCT) begin
            mode = M_PLAIN;
          end else begin
            spec_pos = 0;
            acc = 0;
            have_digits = 0;
            if (is_digit(c)) begin
              add_digit(c);
              mode = M_POSN;
            end else begin
              walk(c);
            end
          end
        end
        M_POSN: begin
          if (is_digit(c)) begin
            add_digit(c);
          end else if (c == K_DOLLAR) begin
            spec_pos = acc;
            note_pos(acc);
            mode = M_WALK;
          end else begin
            spec_pos = 0;
            walk(c);
          end
        end
        M_STAR: begin
          if (is_digit(c)) begin
            add_digit(c);
          end else if (c == K_DOLLAR && have_digits) begin
            if (acc > 0) note_pos(acc);
            else bump();
            mode = M_WALK;
          end else begin
            bump();
            walk(c);
          end
        end
        default: walk(c);
      endcase
      if (last) begin
        if (mode == M_STAR) bump();
        n = pos_seen ? max_pos : seq_cnt;
        r.cnt = (n > 255) ? 8'd255 : 8'(n);
        r.pos = pos_seen;
        expected_q.push_back(r);
        clear();
      end
    endfunction

    function void check_result(logic [7:0] cnt, logic pos);
      arg_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result arg_count=%0d uses_positions=%0b",
                 $time, cnt, pos);
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (e.pos) n_positional++;
      if (e.cnt == 8'd255) n_saturated++;
      if (cnt !== e.cnt) begin
        errors++;
        $display("%0t: arg_count mismatch expected=%0d actual=%0d", $time, e.cnt, cnt);
      end
      if (pos !== e.pos) begin
        errors++;
        $display("%0t: uses_positions mismatch expected=%0b actual=%0b",
                 $time, e.pos, pos);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] char_code = 8'h00;
  logic       last_char = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] arg_count;
  logic       uses_positions;

  arg_count_sb sb = new();
  logic [7:0]  str_q[$];
  bit          calm = 0;
  int          n_bytes = 0;
  int          n_strings = 0;
  int          n_drains = 0;

  printf_format_arg_counter dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .char_code(char_code),
    .last_char(last_char),
    .empty(empty),
    .pop(pop),
    .arg_count(arg_count),
    .uses_positions(uses_positions)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // mostly short gaps, a few long ones, none at all while calm
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: pop with random stalls, check on every accepted pop
  initial begin : result_side
    int  stall;
    bit  got;
    stall = 0;
    forever begin
      @(posedge clk);
      got = 0;
      if (!rst && pop && !empty) begin
        sb.check_result(arg_count, uses_positions);
        got = 1;
      end
      @(negedge clk);
      if (got) stall = idle_len();
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // entered and left at a falling edge
  task automatic push_byte(input logic [7:0] c, input logic l);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      char_code <= 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    char_code <= c;
    last_char <= l;
    do @(posedge clk); while (full);
    sb.note_byte(c, l);
    n_bytes++;
    @(negedge clk);
  endtask

  task automatic send_queue();
    for (int i = 0; i < str_q.size(); i++) push_byte(str_q[i], i == str_q.size() - 1);
    n_strings++;
  endtask

  task automatic hold_until_drained();
    push <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    n_drains++;
  endtask

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endfunction

  task automatic send_str(string s);
    str_q.delete();
    put_str(s);
    send_queue();
  endtask

  function automatic void put_num();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 75) n = $urandom_range(1, 9);
    else if (r < 90) n = $urandom_range(0, 99);
    else n = $urandom_range(0, 999);
    put_str($sformatf("%0d", n));
  endfunction

  // width or precision: nothing, digits, star, or positional star
  function automatic void put_field();
    case ($urandom_range(0, 3))
      0: ;
      1: put_num();
      2: put_str("*");
      default: begin
        put_str("*");
        put_num();
        put_str("$");
      end
    endcase
  endfunction

  function automatic void put_spec();
    string flags;
    string convs;
    flags = "-+ #0";
    convs = "diouxXeEfFgGaAcspn";
    put_str("%");
    if ($urandom_range(0, 2) == 0) begin
      put_num();
      put_str("$");
    end
    repeat ($urandom_range(0, 2)) str_q.push_back(flags[$urandom_range(0, 4)]);
    if ($urandom_range(0, 1)) put_field();
    if ($urandom_range(0, 2) == 0) begin
      put_str(".");
      put_field();
    end
    case ($urandom_range(0, 8))
      0: ;
      1: put_str("l");
      2: put_str("ll");
      3: put_str("h");
      4: put_str("hh");
      5: put_str("L");
      6: put_str("z");
      7: put_str("j");
      default: put_str("t");
    endcase
    if ($urandom_range(0, 9) == 0)
      str_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(65, 90))
                                           : 8'($urandom_range(97, 122)));
    else
      str_q.push_back(convs[$urandom_range(0, convs.len() - 1)]);
  endfunction

  function automatic void gen_string();
    int r;
    int keep;
    str_q.delete();
    r = $urandom_range(0, 99);
    if (r < 85) begin
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(0, 5))
          0, 1: repeat ($urandom_range(1, 4)) str_q.push_back(8'($urandom_range(32, 126)));
          2: put_str("%%");
          default: put_spec();
        endcase
      end
      // broken sequence: cut anywhere, often mid-spec
      if (r >= 70) begin
        keep = $urandom_range(1, str_q.size());
        while (str_q.size() > keep) void'(str_q.pop_back());
      end
    end else begin
      repeat ($urandom_range(1, 12)) str_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin : request_side
    int stars;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_str("%d");
    send_str("%%");
    send_str("abc");
    send_str("d");
    send_str("%1$d %2$s");
    send_str("%*d");
    send_str("%*3$d %1$d");
    send_str("%0$d");
    send_str("%*0$d");
    send_str("%*$d");
    send_str("%*");
    send_str("%*5");
    send_str("%");
    send_str("%5");
    send_str("%5d");
    send_str("%255$d");
    send_str("%256$d %999$i");
    send_str("%lld%hhd%Lf%zu%jd%td");
    send_str("%1$*2$d");
    send_str("%2$d %d");
    send_str("%.*f%-+ #08.3x");
    // bytes above 127 are neither digits nor letters
    str_q.delete();
    put_str("%");
    str_q.push_back(8'hC8);
    put_str("d%");
    str_q.push_back(8'hFF);
    str_q.push_back(8'h80);
    str_q.push_back(8'h00);
    str_q.push_back(8'h7F);
    put_str("Z");
    send_queue();
    hold_until_drained();

    // long star run saturates the sequential count
    str_q.delete();
    put_str("%");
    stars = $urandom_range(260, 300);
    repeat (stars) put_str("*");
    put_str("d");
    send_queue();

    n_bytes = 0;
    while (n_bytes < RAND_BYTES) begin
      calm = ($urandom_range(0, 7) == 0);
      gen_string();
      send_queue();
      if ($urandom_range(0, 14) == 0) hold_until_drained();
    end
    calm = 0;

    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    $display("Ran %0d format strings, %0d results checked (%0d positional, %0d at 255)",
             n_strings, sb.n_checked, sb.n_positional, sb.n_saturated);
    $display("Random bytes %0d, sender drained %0d times, %0d errors",
             n_bytes, n_drains, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
